[rtl/core/cobs_sd_pkg.sv]
// Shared types, codes and helpers for the COBS stream decoder.
// No dependencies.
package cobs_sd_pkg;

    localparam int MAX_FRAME = 1024;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic [BYTE_W-1:0] CODE_FULL = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE   = 2'd0,
        CMD_END    = 2'd1,
        CMD_RESYNC = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_PACKET = 2'd1,
        MODE_RESYNC = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [BYTE_W-1:0] block_code;
        logic [BYTE_W-1:0] bytes_left;
        logic [LEN_W-1:0]  frame_count;
    } dec_state_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  frame_length;
    } dec_result_t;

    // Limit in force: the smaller of the register and MAX_FRAME.
    function automatic logic [LEN_W-1:0] frame_limit(input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] lim;
        lim = max_len;
        if (32'(max_len) > MAX_FRAME) begin
            lim = LEN_W'(MAX_FRAME);
        end
        return lim;
    endfunction

endpackage

[rtl/core/cobs_sd_step.sv]
// Next-state and result logic for one decoder transfer.
// Depends on cobs_sd_pkg.
module cobs_sd_step
    import cobs_sd_pkg::*;
(
    input  dec_state_t        state_cur,
    input  cmd_t              cmd,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  limit,
    output dec_state_t        state_next,
    output dec_result_t       result
);

    logic at_limit;

    assign at_limit = (state_cur.frame_count >= limit);

    always_comb begin
        state_next = state_cur;
        result     = '{valid: 1'b0, kind: KIND_DATA, out_byte: '0, frame_length: '0};

        unique case (cmd)
            CMD_BYTE: begin
                unique case (state_cur.mode)
                    MODE_RESYNC: begin
                        if (data_byte == '0) begin
                            state_next.mode        = MODE_IDLE;
                            state_next.frame_count = '0;
                        end
                    end
                    MODE_PACKET: begin
                        if (data_byte == '0) begin
                            state_next.mode = MODE_IDLE;
                            result.valid    = 1'b1;
                            if (state_cur.bytes_left == '0) begin
                                result.kind         = KIND_DONE;
                                result.frame_length = state_cur.frame_count;
                            end else begin
                                result.kind            = KIND_ABORT;
                                state_next.frame_count = '0;
                            end
                        end else if (state_cur.bytes_left != '0) begin
                            result.valid = 1'b1;
                            if (at_limit) begin
                                result.kind            = KIND_ABORT;
                                state_next.mode        = MODE_RESYNC;
                                state_next.frame_count = '0;
                            end else begin
                                result.kind            = KIND_DATA;
                                result.out_byte        = data_byte;
                                state_next.frame_count = state_cur.frame_count + 1'b1;
                                state_next.bytes_left  = state_cur.bytes_left - 1'b1;
                            end
                        end else if (state_cur.block_code != CODE_FULL && at_limit) begin
                            result.valid           = 1'b1;
                            result.kind            = KIND_ABORT;
                            state_next.mode        = MODE_RESYNC;
                            state_next.frame_count = '0;
                        end else begin
                            // new code byte; implied zero unless previous block was full
                            if (state_cur.block_code != CODE_FULL) begin
                                result.valid           = 1'b1;
                                result.kind            = KIND_DATA;
                                state_next.frame_count = state_cur.frame_count + 1'b1;
                            end
                            state_next.block_code = data_byte;
                            state_next.bytes_left = data_byte - 1'b1;
                        end
                    end
                    default: begin
                        state_next.mode = MODE_IDLE;
                        if (data_byte != '0) begin
                            state_next.block_code  = data_byte;
                            state_next.bytes_left  = data_byte - 1'b1;
                            state_next.mode        = MODE_PACKET;
                            state_next.frame_count = '0;
                        end
                    end
                endcase
            end
            CMD_END: begin
                if (state_cur.mode == MODE_PACKET && state_cur.bytes_left == '0) begin
                    state_next.mode     = MODE_IDLE;
                    result.valid        = 1'b1;
                    result.kind         = KIND_DONE;
                    result.frame_length = state_cur.frame_count;
                end
            end
            CMD_RESYNC: begin
                state_next.mode        = MODE_RESYNC;
                state_next.block_code  = '0;
                state_next.bytes_left  = '0;
                state_next.frame_count = '0;
                if (state_cur.mode == MODE_PACKET) begin
                    result.valid = 1'b1;
                    result.kind  = KIND_ABORT;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/cobs_sd_oreg.sv]
// Output register of the decoder: holds one result until the master side takes it.
// Depends on cobs_sd_pkg.
module cobs_sd_oreg
    import cobs_sd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  dec_result_t           result,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [KIND_W-1:0]     m_tuser
);

    logic              valid_reg;
    kind_t             kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  len_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= push;
        end
        if (free && push) begin
            kind_reg <= result.kind;
            byte_reg <= result.out_byte;
            len_reg  <= result.frame_length;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {(M_DATA_W - BYTE_W - LEN_W)'(0), len_reg, byte_reg};

endmodule

[rtl/core/cobs_stream_decoder.sv]
// Top level of the COBS stream decoder: input register, decode step, output register.
// Depends on cobs_sd_pkg, cobs_sd_step and cobs_sd_oreg.
//
// Slave side: one transfer per encoded byte; s_tuser carries the command
// (byte, end of input, force resync), s_tdata the byte. Master side: at most
// one transfer per input transfer; m_tuser is the kind (data byte, frame
// complete, frame aborted), m_tdata the decoded byte and frame length.
// An abort tells the consumer to drop the bytes of the open frame.
// cfg_wr_en/cfg_wr_data write the maximum frame length; write it only while
// the decoder is idle.
// Path: an input transfer is registered in the input register, and its
// result in the output register, which drives m_tvalid. Throughput: one transfer
// per cycle while the master side keeps up; the decode step is combinational
// logic on the registered item.
// Reset: decoder idle, limit 1024, both registers empty.
// Stall: when m_tready is low the output register holds its result; one more
// item is still taken into the input register, and s_tready drops only when
// that item has a result that cannot move.
module cobs_stream_decoder
    import cobs_sd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic [CMD_W-1:0]    s_tuser,   // [1:0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] out_byte, [18:8] frame_length, zero pad
    output logic [KIND_W-1:0]   m_tuser,   // [1:0] kind
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data
);

    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [LEN_W-1:0]  max_len_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_result_t       result;
    logic              out_free;
    logic              fire;

    assign fire     = in_valid_reg && (!result.valid || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= LEN_W'(1024);
            state_reg    <= '{mode: MODE_IDLE, block_code: '0, bytes_left: '0,
                              frame_count: '0};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (fire) begin
                state_reg <= state_next;
            end
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= cmd_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    cobs_sd_step u_step (
        .state_cur  (state_reg),
        .cmd        (in_cmd_reg),
        .data_byte  (in_byte_reg),
        .limit      (frame_limit(max_len_reg)),
        .state_next (state_next),
        .result     (result)
    );

    cobs_sd_oreg u_oreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fire && result.valid),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/cobs_sd_checker.sv]
// Port-level checks for the COBS stream decoder, bound to the top level.
// Depends on cobs_sd_pkg and cobs_stream_decoder.
module cobs_sd_checker
    import cobs_sd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]   m_tuser
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_field_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_DATA && m_tdata[M_DATA_W-1:BYTE_W] == '0)
                  || (m_tuser == KIND_DONE && m_tdata[BYTE_W-1:0] == '0
                      && m_tdata[M_DATA_W-1:BYTE_W+LEN_W] == '0)
                  || (m_tuser == KIND_ABORT && m_tdata == '0))
        else $error("bad kind or unused field not zero");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DONE |-> 32'(m_tdata[BYTE_W+LEN_W-1:BYTE_W]) <= MAX_FRAME)
        else $error("frame length above limit");

endmodule

bind cobs_stream_decoder cobs_sd_checker u_cobs_sd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
